[src/bpfv_pkg.sv]
package bpfv_pkg;

	localparam int unsigned MAX_INSNS = 4096;
	localparam int unsigned PC_W      = $clog2(MAX_INSNS);
	localparam int unsigned LEN_W     = PC_W + 1;
	localparam int unsigned TGT_W     = 18;
	localparam int unsigned Q_DEPTH   = 2;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_INSNS);

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_ARG = 2'd1,
		ST_VAL = 2'd2
	} verdict_t;

	localparam logic [2:0] CLS_LDX   = 3'h1;
	localparam logic [2:0] CLS_ALU   = 3'h4;
	localparam logic [2:0] CLS_JMP   = 3'h5;
	localparam logic [2:0] CLS_JMP32 = 3'h6;
	localparam logic [2:0] CLS_ALU64 = 3'h7;

	localparam logic [3:0] HI_CALL = 4'h8;
	localparam logic [3:0] HI_EXIT = 4'h9;
	localparam logic [3:0] HI_ENDIAN = 4'hd;
	localparam logic [3:0] HI_ALU_MAX = 4'hc;
	localparam logic [2:0] LDX_MEM_MODE = 3'h3;
	localparam logic [3:0] MAX_REG = 4'd10;
	localparam logic [31:0] MAX_HELPER = 32'd2;

	// decoded instruction, pc-independent part
	typedef struct packed {
		logic        bad;
		logic        need_target;
		logic [15:0] offset;
	} bpfv_cls_t;

endpackage

[src/bpfv_front.sv]
module bpfv_front import bpfv_pkg::*; (
	input  logic [63:0] insn_word,
	output bpfv_cls_t   cls
);

	logic [7:0]  op;
	logic [3:0]  dst;
	logic [3:0]  src;
	logic [31:0] imm;
	logic [2:0]  opc;
	logic [3:0]  hi;
	logic        is_jmp;
	logic        op_ok;
	logic        call_bad;

	assign op     = insn_word[7:0];
	assign dst    = insn_word[11:8];
	assign src    = insn_word[15:12];
	assign imm    = insn_word[63:32];
	assign opc    = op[2:0];
	assign hi     = op[7:4];
	assign is_jmp = (opc == CLS_JMP) || (opc == CLS_JMP32);

	always_comb begin
		unique case (opc)
			CLS_LDX: begin
				op_ok = (op[7:5] == LDX_MEM_MODE);
			end
			CLS_ALU, CLS_ALU64: begin
				op_ok = (hi == HI_ENDIAN) ? op[3] : (hi <= HI_ALU_MAX);
			end
			CLS_JMP, CLS_JMP32: begin
				op_ok = (hi != 4'he) && (hi != 4'hf);
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	assign call_bad = is_jmp && (hi == HI_CALL) && (op[3] || (imm > MAX_HELPER));

	assign cls.bad         = (dst > MAX_REG) || (src > MAX_REG) || !op_ok || call_bad;
	assign cls.need_target = is_jmp && (hi != HI_CALL) && (hi != HI_EXIT);
	assign cls.offset      = insn_word[31:16];

endmodule

[src/bpfv_queue.sv]
module bpfv_queue import bpfv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bpfv_cls_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output bpfv_cls_t head
);

	localparam int unsigned PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

	bpfv_cls_t        slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/bpfv_back.sv]
module bpfv_back import bpfv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LEN_W-1:0] prog_len,
	input  logic             q_valid,
	input  bpfv_cls_t        q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       verdict,
	output logic             done_res,
	output logic [PC_W-1:0]  position
);

	logic [PC_W-1:0]         pc_q;
	verdict_t                status_q;
	logic                    out_valid_q;
	verdict_t                verdict_s1;
	logic                    done_s1;
	logic [PC_W-1:0]         pos_s1;

	logic                    len_bad;
	logic signed [TGT_W-1:0] target;
	logic                    tgt_bad;
	logic                    chk_bad;
	verdict_t                new_status;
	logic                    last;
	verdict_t                res_verdict;
	logic                    res_done;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	assign len_bad = (prog_len == '0) || (prog_len > MAX_LEN);
	assign target  = $signed({{(TGT_W - PC_W){1'b0}}, pc_q}) + TGT_W'(1)
		+ $signed({{(TGT_W - 16){q_head.offset[15]}}, q_head.offset});
	assign tgt_bad = target[TGT_W-1]
		|| (target >= $signed({{(TGT_W - LEN_W){1'b0}}, prog_len}));
	assign chk_bad = q_head.bad || (q_head.need_target && tgt_bad);
	assign new_status = (status_q != ST_OK) ? status_q : (chk_bad ? ST_VAL : ST_OK);
	assign last = ({1'b0, pc_q} + LEN_W'(1)) >= prog_len;

	assign res_verdict = len_bad ? ST_ARG : new_status;
	assign res_done    = len_bad || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				if (res_done) begin
					pc_q     <= '0;
					status_q <= ST_OK;
				end else begin
					pc_q     <= pc_q + 1'b1;
					status_q <= new_status;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			verdict_s1 <= res_verdict;
			done_s1    <= res_done;
			pos_s1     <= pc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_s1;
	assign done_res  = done_s1;
	assign position  = pos_s1;

endmodule

[src/bpf_program_validator.sv]
// Checks an eBPF program one 64-bit instruction per request and returns one
// result per request: the sticky verdict so far (0 ok, 1 bad length, 2 invalid
// instruction), a done flag on the last instruction, and the instruction's
// position. Set program_length while the block is idle; a length of 0 or above
// 4096 flags every request as a bad length and done. Throughput is one request
// per cycle unless out_stall holds: a decode front end feeds a two-entry queue,
// and the back end (position counter, jump-target add and compare, result
// register) retires one entry each cycle.
module bpf_program_validator import bpfv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] program_length,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [63:0]      insn_word,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       verdict,
	output logic             done_res,
	output logic [PC_W-1:0]  position
);

	logic [LEN_W-1:0] prog_len_q;
	bpfv_cls_t        cls;
	bpfv_cls_t        q_head;
	logic             q_full;
	logic             q_valid;
	logic             q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			prog_len_q <= program_length;
		end
	end

	bpfv_front u_front (
		.insn_word (insn_word),
		.cls       (cls)
	);

	assign in_stall = q_full;

	bpfv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_data (cls),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	bpfv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.prog_len  (prog_len_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.verdict   (verdict),
		.done_res  (done_res),
		.position  (position)
	);

endmodule

[src/bpfv_checker.sv]
module bpfv_checker import bpfv_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [LEN_W-1:0] program_length,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       verdict,
	input logic             done_res,
	input logic [PC_W-1:0]  position
);

	logic            out_acc;
	logic [PC_W-1:0] exp_pos_q;
	logic            sticky_val_q;
	logic            len_bad_q;

	assign out_acc = out_valid && !out_stall;

	// a bad length overrides the sticky status with an argument error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_bad_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			len_bad_q <= (program_length == '0) || (program_length > MAX_LEN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_pos_q    <= '0;
			sticky_val_q <= 1'b0;
		end else if (out_acc) begin
			exp_pos_q    <= done_res ? '0 : position + 1'b1;
			sticky_val_q <= !done_res && (verdict == ST_VAL);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict)
			&& $stable(done_res) && $stable(position))
		else $error("stalled result changed");

	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> position == exp_pos_q)
		else $error("position out of sequence");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && sticky_val_q && !len_bad_q |-> verdict == ST_VAL)
		else $error("validation error not sticky");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict != 2'd3)
		else $error("undefined verdict code");

endmodule

bind bpf_program_validator bpfv_checker u_bpfv_checker (.*);

[bench/bpf_program_validator_tb.sv]
`timescale 1ns / 1ps

module bpf_program_validator_tb;
	import bpfv_pkg::*;

	localparam logic [3:0] HI_JMP_MAX = 4'hd;

	typedef struct {
		verdict_t         v;
		logic             last;
		logic [PC_W-1:0]  pos;
	} insn_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEN_W-1:0]  program_length = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [63:0]       insn_word = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        verdict;
	logic              done_res;
	logic [PC_W-1:0]   position;

	logic [63:0]       pend_q[$];
	insn_result_t      result_q[$];
	int                n_total = 0;
	int                n_got = 0;
	int                fails = 0;
	int                send_idle = 0;
	int                recv_stall = 0;

	// checker state
	logic [LEN_W-1:0]  len_cfg = '0;
	int unsigned       pc_cnt = 0;
	verdict_t          sticky = ST_OK;

	bpf_program_validator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.program_length (program_length),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.insn_word      (insn_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.done_res       (done_res),
		.position       (position)
	);

	always #5 clk = ~clk;

	function automatic verdict_t insn_check(logic [63:0] w, int unsigned pc, int unsigned cnt);
		logic [7:0] op;
		logic [3:0] hi;
		logic [2:0] cls;
		bit         op_ok;
		int         tgt;
		op = w[7:0];
		hi = op[7:4];
		cls = op[2:0];
		case (cls)
			CLS_LDX: op_ok = (op[7:5] == LDX_MEM_MODE);
			CLS_ALU, CLS_ALU64: op_ok = (hi == HI_ENDIAN) ? op[3] : (hi <= HI_ALU_MAX);
			CLS_JMP, CLS_JMP32: op_ok = (hi <= HI_JMP_MAX);
			default: op_ok = 1'b0;
		endcase
		if (w[11:8] > MAX_REG || w[15:12] > MAX_REG || !op_ok)
			return ST_VAL;
		if (cls != CLS_JMP && cls != CLS_JMP32)
			return ST_OK;
		if (hi == HI_EXIT)
			return ST_OK;
		if (hi == HI_CALL)
			return (op[3] || w[63:32] > MAX_HELPER) ? ST_VAL : ST_OK;
		tgt = int'(pc) + 1 + int'($signed(w[31:16]));
		return (tgt < 0 || tgt >= int'(cnt)) ? ST_VAL : ST_OK;
	endfunction

	function automatic void predict(logic [63:0] w);
		insn_result_t r;
		if (len_cfg == 0 || len_cfg > MAX_LEN) begin
			r.v = ST_ARG;
			r.last = 1'b1;
		end else begin
			if (sticky == ST_OK)
				sticky = insn_check(w, pc_cnt, len_cfg);
			r.v = sticky;
			r.last = (pc_cnt + 1 >= len_cfg);
		end
		r.pos = pc_cnt[PC_W-1:0];
		if (r.last) begin
			pc_cnt = 0;
			sticky = ST_OK;
		end else begin
			pc_cnt++;
		end
		result_q.push_back(r);
	endfunction

	function automatic logic [63:0] mk(logic [7:0] op, logic [3:0] dst, logic [3:0] src,
			logic [15:0] off, logic [31:0] imm);
		return {imm, off, src, dst, op};
	endfunction

	// well-formed instruction for position pc of a program of len items
	function automatic logic [63:0] good_insn(int unsigned pc, int unsigned len);
		logic [7:0]  op;
		logic [3:0]  hi;
		logic [15:0] off;
		logic [31:0] imm;
		off = 16'($urandom);
		imm = $urandom;
		case ($urandom_range(2))
			0: op = {LDX_MEM_MODE, 2'($urandom), CLS_LDX};
			1: begin
				hi = 4'($urandom_range(HI_ENDIAN));
				op = {hi, 1'($urandom), $urandom_range(1) ? CLS_ALU : CLS_ALU64};
				if (hi == HI_ENDIAN)
					op[3] = 1'b1;
			end
			default: begin
				hi = 4'($urandom_range(HI_JMP_MAX));
				op = {hi, 1'($urandom), $urandom_range(1) ? CLS_JMP : CLS_JMP32};
				if (hi == HI_CALL) begin
					op[3] = 1'b0;
					imm = $urandom_range(MAX_HELPER);
				end else if (hi != HI_EXIT) begin
					off = 16'(int'($urandom_range(len - 1)) - int'(pc) - 1);
				end
			end
		endcase
		return mk(op, 4'($urandom_range(MAX_REG)), 4'($urandom_range(MAX_REG)), off, imm);
	endfunction

	function automatic logic [63:0] broken_insn(logic [63:0] w, int unsigned pc, int unsigned len);
		case ($urandom_range(5))
			0: w = {$urandom, $urandom};
			1: w[11:8] = 4'($urandom_range(11, 15));
			2: w[15:12] = 4'($urandom_range(11, 15));
			3: w[7:0] = 8'($urandom);
			4: begin
				w[7:0] = {4'($urandom_range(7)), 1'($urandom), CLS_JMP};
				w[31:16] = $urandom_range(1) ? 16'(-int'(pc) - 2) : 16'(int'(len) - int'(pc) - 1);
			end
			default: begin
				w[7:0] = {HI_CALL, 1'b0, CLS_JMP32};
				w[63:32] = $urandom_range(32'hffff_ffff, 3);
			end
		endcase
		return w;
	endfunction

	task automatic send(logic [63:0] w);
		pend_q.push_back(w);
		n_total++;
	endtask

	task automatic write_len(logic [LEN_W-1:0] len, int mode);
		while (n_got < n_total)
			@(posedge clk);
		repeat (3) @(posedge clk);
		send_idle = (mode == 1) ? 79 : (mode == 3) ? 31 : 0;
		recv_stall = (mode == 2) ? 79 : (mode == 3) ? 31 : 0;
		cfg_valid <= 1'b1;
		program_length <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		len_cfg = len;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			insn_word <= '0;
		end else begin
			if (in_valid && !in_stall)
				predict(insn_word);
			if (!in_valid || !in_stall) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					insn_word <= pend_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		insn_result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: verdict %0d done_res %0b position %0d",
						verdict, done_res, position);
					fails++;
				end else begin
					e = result_q.pop_front();
					if (verdict !== e.v) begin
						$error("verdict: expected %0d, got %0d", e.v, verdict);
						fails++;
					end
					if (done_res !== e.last) begin
						$error("done_res: expected %0b, got %0b", e.last, done_res);
						fails++;
					end
					if (position !== e.pos) begin
						$error("position: expected %0d, got %0d", e.pos, position);
						fails++;
					end
				end
				n_got++;
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [LEN_W-1:0] len;
		logic [63:0]      w;
		int unsigned      pc;
		int               n;
		int               n_rand;
		int               phase;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// zero length straight out of reset
		send(64'h0);
		send('1);

		write_len(8, 0);
		send(mk(8'h61, 10, 10, 16'h8000, 32'hffff_ffff));
		send(mk(8'h07, 0, 0, 16'h0, 32'h0));
		send(mk(8'hdc, 3, 0, 16'h0, 32'd16));
		send(mk(8'h85, 0, 0, 16'h0, 32'd2));
		send(mk(8'h05, 0, 0, 16'd2, 32'h0));
		send(mk(8'h16, 1, 2, 16'hfffa, 32'h0));
		send(mk(8'h95, 0, 0, 16'h0, 32'h0));
		send(mk(8'h05, 0, 0, 16'h0, 32'h0));

		// first error sticks
		write_len(4, 0);
		send(mk(8'hd4, 1, 0, 16'h0, 32'd32));
		send(mk(8'he5, 0, 0, 16'h0, 32'h0));
		send(mk(8'hb7, 1, 0, 16'h0, 32'd5));
		send(mk(8'h95, 0, 0, 16'h0, 32'h0));

		// one-item programs, one bad field each but the last, which is valid
		write_len(1, 0);
		send(mk(8'h8d, 0, 0, 16'h0, 32'h0));
		send(mk(8'h85, 0, 0, 16'h0, 32'd3));
		send(mk(8'hb7, 11, 0, 16'h0, 32'h0));
		send(mk(8'h0f, 0, 15, 16'h0, 32'h0));
		send(mk(8'hf5, 0, 0, 16'h0, 32'h0));
		send(mk(8'h05, 0, 0, 16'hfffe, 32'h0));
		send(mk(8'h05, 0, 0, 16'hffff, 32'h0));

		// length cut below the current position
		write_len(10, 0);
		for (int i = 0; i < 5; i++)
			send(good_insn(i, 10));
		write_len(3, 0);
		send(good_insn(5, 10));

		write_len(MAX_LEN, 0);
		send(mk(8'h05, 0, 0, 16'd4094, 32'h0));
		send(mk(8'h05, 0, 0, 16'd4094, 32'h0));
		write_len('1, 0);
		send(good_insn(0, 1));

		n_rand = 0;
		phase = 0;
		while (n_rand < 850) begin
			case ($urandom_range(9))
				0: len = '0;
				1: len = MAX_LEN;
				2: len = $urandom_range(1) ? '1 : LEN_W'($urandom_range(8191, MAX_INSNS + 1));
				3: len = 1;
				default: len = LEN_W'($urandom_range(40, 2));
			endcase
			write_len(len, phase % 4);
			n = $urandom_range(60, 10);
			pc = pc_cnt;
			for (int i = 0; i < n; i++) begin
				if (len == 0 || len > MAX_LEN) begin
					w = {$urandom, $urandom};
				end else begin
					w = good_insn(pc, len);
					if ($urandom_range(99) < 5)
						w = broken_insn(w, pc, len);
					pc = (pc + 1 >= len) ? 0 : pc + 1;
				end
				send(w);
			end
			n_rand += n;
			phase++;
		end

		while (n_got < n_total)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0 && result_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
